FILE: rtl/rlpaq_pkg.sv
// rlpaq_pkg: shared constants and types for the announce queue
// holds the queue sizing, register indexes and the controller/datapath structs
// no dependencies
`timescale 1ns / 1ps

package rlpaq_pkg;

    localparam int DEPTH     = 16;
    localparam int MSG_W     = 16;
    localparam int CLS_W     = 3;
    localparam int TICK_W    = 16;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W     = $clog2(DEPTH + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COAL_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COAL_CLS = 2'd2;

    localparam logic [TICK_W-1:0] INTERVAL_RST = 16'd45;
    localparam logic [CLS_W-1:0]  COAL_CLS_RST = 3'd2;

    localparam logic EV_POP  = 1'b0;
    localparam logic EV_DROP = 1'b1;

    typedef struct packed {
        logic load;       // latch the accepted word
        logic scan_step;  // advance the walk pointer
        logic coal;       // replace the handle at the pointer
        logic insert;     // open a slot at the pointer and store
        logic drop;       // report the word as dropped
        logic tick;       // advance the counter, pop if due
    } t_cmd;

    typedef struct packed {
        logic scan_le;    // entry at pointer has class not above the new one
        logic scan_coal;  // entry at pointer can take the new handle
        logic full;
        logic pop_due;
        logic out_busy;   // result slot still held
    } t_stat;

endpackage

FILE: rtl/rlpaq_ctrl.sv
// rlpaq_ctrl: sequencer for the announce queue
// walks the sorted entries on insert and orders tick handling
// depends on rlpaq_pkg
`timescale 1ns / 1ps

module rlpaq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_mode,
    output logic              o_in_ready,
    input  rlpaq_pkg::t_stat  i_stat,
    output rlpaq_pkg::t_cmd   o_cmd
);
    import rlpaq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TICK = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_mode ? S_SCAN : S_TICK;
                end
            end
            S_TICK: begin
                // a pop needs a free result slot before anything changes
                if (!(i_stat.pop_due && i_stat.out_busy)) begin
                    o_cmd.tick = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                priority if (i_stat.scan_coal) begin
                    o_cmd.coal = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_stat.scan_le) begin
                    o_cmd.scan_step = 1'b1;
                end else if (i_stat.full) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.drop = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/rlpaq_dp.sv
// rlpaq_dp: entry store, counters, config registers and result register
// driven by rlpaq_ctrl through t_cmd, reports back through t_stat
// depends on rlpaq_pkg
`timescale 1ns / 1ps

module rlpaq_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rlpaq_pkg::t_cmd                 i_cmd,
    output rlpaq_pkg::t_stat                o_stat,
    input  logic [rlpaq_pkg::CLS_W-1:0]     i_msg_class,
    input  logic [rlpaq_pkg::MSG_W-1:0]     i_message,
    input  logic                            i_cfg_valid,
    input  logic [rlpaq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rlpaq_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_event_res,
    output logic [rlpaq_pkg::CLS_W-1:0]     o_out_class,
    output logic [rlpaq_pkg::MSG_W-1:0]     o_out_message
);
    import rlpaq_pkg::*;

    logic [CLS_W-1:0]  r_cls [DEPTH];
    logic [MSG_W-1:0]  r_msg [DEPTH];

    logic [CLS_W-1:0]  r_cls_in;
    logic [MSG_W-1:0]  r_msg_in;
    logic [PTR_W-1:0]  r_ptr;
    logic [PTR_W-1:0]  r_count;
    logic [TICK_W-1:0] r_elapsed;
    logic [TICK_W-1:0] r_interval;
    logic              r_coal_en;
    logic [CLS_W-1:0]  r_coal_cls;

    logic              r_out_valid;
    logic              r_ev;
    logic [CLS_W-1:0]  r_out_cls;
    logic [MSG_W-1:0]  r_out_msg;

    logic [IDX_W-1:0]  cur_idx;
    logic [CLS_W-1:0]  cur_cls;
    logic              in_range;
    logic [TICK_W-1:0] elapsed_inc;
    logic              popping;
    logic              set_out;

    assign cur_idx     = r_ptr[IDX_W-1:0];
    assign in_range    = (r_ptr < r_count);
    assign cur_cls     = r_cls[cur_idx];
    assign elapsed_inc = (r_elapsed != '1) ? r_elapsed + 1'b1 : r_elapsed;
    assign popping     = i_cmd.tick && o_stat.pop_due;
    assign set_out     = popping || i_cmd.drop;

    always_comb begin
        o_stat.scan_le   = in_range && (cur_cls <= r_cls_in);
        o_stat.scan_coal = in_range && (cur_cls == r_cls_in) && r_coal_en
                           && (r_cls_in == r_coal_cls);
        o_stat.full      = (r_count == PTR_W'(DEPTH));
        o_stat.pop_due   = (elapsed_inc > r_interval) && (r_count != '0);
        o_stat.out_busy  = r_out_valid && !i_out_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_elapsed   <= '0;
            r_interval  <= INTERVAL_RST;
            r_coal_en   <= 1'b1;
            r_coal_cls  <= COAL_CLS_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_INTERVAL: r_interval <= i_cfg_data[TICK_W-1:0];
                    REG_COAL_EN:  r_coal_en  <= i_cfg_data[0];
                    REG_COAL_CLS: r_coal_cls <= i_cfg_data[CLS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.tick) begin
                r_elapsed <= popping ? '0 : elapsed_inc;
            end
            if (popping) begin
                r_count <= r_count - 1'b1;
            end else if (i_cmd.insert) begin
                r_count <= r_count + 1'b1;
            end
            if (set_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: entries, walk pointer, latched word, result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cls_in <= i_msg_class;
            r_msg_in <= i_message;
            r_ptr    <= '0;
        end else if (i_cmd.scan_step) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (popping) begin
            r_ev      <= EV_POP;
            r_out_cls <= r_cls[0];
            r_out_msg <= r_msg[0];
        end else if (i_cmd.drop) begin
            r_ev      <= EV_DROP;
            r_out_cls <= r_cls_in;
            r_out_msg <= r_msg_in;
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (popping) begin
                if (i < DEPTH - 1) begin
                    r_cls[i] <= r_cls[(i + 1) % DEPTH];
                    r_msg[i] <= r_msg[(i + 1) % DEPTH];
                end
            end else if (i_cmd.insert) begin
                // entries at and above the pointer move up one slot
                if (PTR_W'(i) == r_ptr) begin
                    r_cls[i] <= r_cls_in;
                    r_msg[i] <= r_msg_in;
                end else if (PTR_W'(i) > r_ptr && i > 0) begin
                    r_cls[i] <= r_cls[(i + DEPTH - 1) % DEPTH];
                    r_msg[i] <= r_msg[(i + DEPTH - 1) % DEPTH];
                end
            end else if (i_cmd.coal && (PTR_W'(i) == r_ptr)) begin
                r_msg[i] <= r_msg_in;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_ev;
    assign o_out_class   = r_out_cls;
    assign o_out_message = r_out_msg;

endmodule

FILE: rtl/rate_limited_priority_announce_queue.sv
// channel | valid      | ready       | payload
// in      | i_in_valid | o_in_ready  | i_mode, i_msg_class, i_message
// out     | o_out_valid| i_out_ready | o_event_res, o_out_class, o_out_message
// cfg     | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
// a tick word is handled in S_TICK; the length of an insert is set by the
// walk over the sorted entries, one entry per cycle in the datapath.
// one word is in work at a time; the result register lets the next word in
// while a result waits, but a pop or drop holds until that register is free.
// reset (synchronous, active low) empties the queue, clears the counter and
// loads the register defaults; the config port is always ready.
`timescale 1ns / 1ps

module rate_limited_priority_announce_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_mode,
    input  logic [rlpaq_pkg::CLS_W-1:0]     i_msg_class,
    input  logic [rlpaq_pkg::MSG_W-1:0]     i_message,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_event_res,
    output logic [rlpaq_pkg::CLS_W-1:0]     o_out_class,
    output logic [rlpaq_pkg::MSG_W-1:0]     o_out_message,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rlpaq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rlpaq_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import rlpaq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    rlpaq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rlpaq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_msg_class   (i_msg_class),
        .i_message     (i_message),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_res   (o_event_res),
        .o_out_class   (o_out_class),
        .o_out_message (o_out_message)
    );

endmodule
